[hdl/bfds_pkg.sv]
// Shared constants, types and functions of the Bloom filter Dice similarity block.
package bfds_pkg;

  localparam int MAX_WORDS = 1024;
  localparam int FRAC_BITS = 16;

  localparam int WORD_W  = 64;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = CNT_W + 1;
  localparam int REM_W   = CNT_W + 2;
  localparam int POP_W   = 7;
  localparam int WCNT_W  = $clog2(MAX_WORDS + 1);
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int QX_W    = (QUO_W > CNT_W) ? QUO_W : CNT_W;
  localparam int ITER_W  = $clog2(FRAC_BITS + 1);
  localparam int IN_DW   = 2 * WORD_W;
  localparam int OUT_FW  = 4 * CNT_W + 1;
  localparam int OUT_DW  = ((OUT_FW + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } bfds_state_t;

  typedef struct packed {
    logic load;   // last beat taken: snapshot counts, set up the divider
    logic step;   // one restoring division step
  } bfds_cmd_t;

  // Population count of one byte.
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // Population count of a 64-bit word: byte counts, then their sum.
  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W / 8; i++) begin
      n = n + POP_W'(pop8(v[i*8 +: 8]));
    end
    return n;
  endfunction

  // Saturating accumulate into a 17-bit count.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                               input logic [POP_W-1:0] inc);
    logic [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(inc);
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

[hdl/bfds_ctrl.sv]
// Controller: sequences accumulation, the serial division and the result beat.
module bfds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output bfds_pkg::bfds_cmd_t cmd
);
  import bfds_pkg::*;

  bfds_state_t       state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              in_fire;
  logic              iter_end;

  // a last beat needs the divider; other beats flow at any time
  assign in_tready = (state_r == ST_IDLE) | ~in_tlast;
  assign in_fire   = in_tvalid & in_tready;
  assign iter_end  = (iter_r == ITER_W'(FRAC_BITS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tlast) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (iter_end) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    out_tvalid = 1'b0;
    iter_nxt   = iter_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_fire & in_tlast;
        iter_nxt = '0;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        iter_nxt = iter_r + 1'b1;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
      end
      default: begin
        iter_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

[hdl/bfds_dp.sv]
// Datapath: popcount accumulators, result snapshot and restoring divider.
module bfds_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [bfds_pkg::WORD_W-1:0] word_a,
  input  logic [bfds_pkg::WORD_W-1:0] word_b,
  input  bfds_pkg::bfds_cmd_t        cmd,
  output logic [bfds_pkg::CNT_W-1:0] coefficient,
  output logic [bfds_pkg::CNT_W-1:0] shared_bits,
  output logic [bfds_pkg::CNT_W-1:0] bits_a,
  output logic [bfds_pkg::CNT_W-1:0] bits_b,
  output logic                       overflow
);
  import bfds_pkg::*;

  // running counts
  logic [CNT_W-1:0]  shared_r, shared_nxt;
  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]  cnt_b_r, cnt_b_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              full;

  // snapshot and divider
  logic [CNT_W-1:0]  h_r, a_r, b_r;
  logic              o_r, zero_r;
  logic [SUM_W-1:0]  div_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [SUM_W-1:0]  den0;
  logic [REM_W-1:0]  rem_sh;
  logic              step_bit;
  logic [QX_W-1:0]   quo_x;

  assign full = (wcnt_r >= WCNT_W'(MAX_WORDS));

  always_comb begin
    shared_nxt = shared_r;
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    wcnt_nxt   = wcnt_r;
    ovf_nxt    = ovf_r;
    if (in_fire) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        shared_nxt = sat_add(shared_r, pop64(word_a & word_b));
        cnt_a_nxt  = sat_add(cnt_a_r, pop64(word_a));
        cnt_b_nxt  = sat_add(cnt_b_r, pop64(word_b));
        wcnt_nxt   = wcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      shared_r <= '0;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      wcnt_r   <= '0;
      ovf_r    <= 1'b0;
    end else begin
      shared_r <= shared_nxt;
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      wcnt_r   <= wcnt_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // remainder starts at h; QUO_W doubling steps give 2h*2^FRAC_BITS/(a+b)
  assign den0 = SUM_W'(cnt_a_nxt) + SUM_W'(cnt_b_nxt);

  assign rem_sh   = {rem_r[REM_W-2:0], 1'b0};
  assign step_bit = (rem_sh >= REM_W'(div_r));

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.load) begin
      rem_nxt = REM_W'(shared_nxt);
      quo_nxt = '0;
    end else if (cmd.step) begin
      rem_nxt = step_bit ? (rem_sh - REM_W'(div_r)) : rem_sh;
      quo_nxt = {quo_r[QUO_W-2:0], step_bit};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.load) begin
      h_r    <= shared_nxt;
      a_r    <= cnt_a_nxt;
      b_r    <= cnt_b_nxt;
      o_r    <= ovf_nxt;
      div_r  <= den0;
      zero_r <= (den0 == '0);
    end
  end

  assign quo_x       = QX_W'(quo_r);
  assign coefficient = zero_r ? '0 : quo_x[CNT_W-1:0];
  assign shared_bits = h_r;
  assign bits_a      = a_r;
  assign bits_b      = b_r;
  assign overflow    = o_r;

endmodule

[hdl/bloom_filter_dice_similarity.sv]
// Top level of the Bloom filter Dice similarity block.
// Two Bloom filters stream in side by side, one 64-bit word of each per input
// beat, with in_tlast on the final pair. Non-last beats are taken at one per
// clock at any time; the popcounts of a&b, a and b are added into saturating
// 17-bit counts, and pairs beyond MAX_WORDS are dropped and flag overflow.
// The last beat snapshots the counts, clears the accumulators and starts a
// restoring divider that yields 2h*2^FRAC_BITS/(a+b), truncated: one quotient
// bit per clock, and the result beat then holds in a register until out_tready.
// A coefficient of 0 is given when both filters are empty. A new filter pair
// can stream in during the division; only its last beat waits (in_tready low)
// until the previous result beat has been taken.
module bloom_filter_dice_similarity (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bfds_pkg::IN_DW-1:0]  in_tdata,   // word_a, word_b
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bfds_pkg::OUT_DW-1:0] out_tdata   // coefficient, shared_bits,
                                                  // bits_a, bits_b, overflow, pad
);
  import bfds_pkg::*;

  bfds_cmd_t        cmd;
  logic             in_fire;
  logic [CNT_W-1:0] coefficient, shared_bits, bits_a, bits_b;
  logic             overflow;

  assign in_fire = in_tvalid & in_tready;

  bfds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bfds_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .word_a      (in_tdata[WORD_W-1:0]),
    .word_b      (in_tdata[IN_DW-1:WORD_W]),
    .cmd         (cmd),
    .coefficient (coefficient),
    .shared_bits (shared_bits),
    .bits_a      (bits_a),
    .bits_b      (bits_b),
    .overflow    (overflow)
  );

  assign out_tdata = OUT_DW'({overflow, bits_b, bits_a, shared_bits, coefficient});

endmodule
